FILE: rtl/plb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plb_pkg;

   // Command from the controller to the datapath for one word.
   typedef struct packed {
      logic load;     // capture the request word
      logic apply;    // update the selected table
      logic publish;  // capture the result word
   } plb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
   } plb_status_type;

endpackage
`default_nettype wire

FILE: rtl/plb_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface plb_if #(parameter int unsigned WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/plb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module plb_datapath #(
   parameter int unsigned MAX_LEVELS = 16,
   parameter int unsigned PRICE_BITS = 32,
   parameter int unsigned QTY_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire plb_pkg::plb_cmd_type    cmd,
   output plb_pkg::plb_status_type      status,
   input  wire logic [PRICE_BITS-1:0]   req_price,
   input  wire logic [QTY_BITS-1:0]     req_qty,
   input  wire logic                    req_side,
   output logic                         rsp_applied,
   output logic [PRICE_BITS-1:0]        rsp_bid,
   output logic [PRICE_BITS-1:0]        rsp_ask,
   output logic [PRICE_BITS:0]          rsp_mid
);
   import plb_pkg::*;

   localparam int unsigned CW = $clog2(MAX_LEVELS + 1);
   localparam int unsigned N = MAX_LEVELS;

   logic [PRICE_BITS-1:0] bpx_ff [N];
   logic [QTY_BITS-1:0]   bq_ff [N];
   logic [PRICE_BITS-1:0] apx_ff [N];
   logic [QTY_BITS-1:0]   aq_ff [N];
   logic [CW-1:0]         bcnt_ff, acnt_ff, bcnt_in, acnt_in;
   logic [PRICE_BITS:0]   mid_ff, mid_in;
   logic [PRICE_BITS-1:0] px_ff;
   logic [QTY_BITS-1:0]   q_ff;
   logic                  side_ff;

   // Per-cell compare flags for the selected table.
   logic [PRICE_BITS-1:0] cpx [N];
   logic [QTY_BITS-1:0]   cq [N];
   logic [CW-1:0]         ccnt;
   logic [N-1:0]          occ, better, equal;
   logic [PRICE_BITS-1:0] npx [N];
   logic [QTY_BITS-1:0]   nq [N];
   logic [CW-1:0]         ncnt;
   logic                  hit, full;

   assign status.busy = 1'b0;

   always_comb begin
      ccnt = side_ff ? bcnt_ff : acnt_ff;
      for (int i = 0; i < N; i++) begin
         cpx[i] = side_ff ? bpx_ff[i] : apx_ff[i];
         cq[i] = side_ff ? bq_ff[i] : aq_ff[i];
         occ[i] = CW'(i) < ccnt;
         equal[i] = occ[i] && (cpx[i] == px_ff);
         better[i] = occ[i] && (side_ff ? (cpx[i] > px_ff) : (cpx[i] < px_ff));
      end
      hit = |equal;
      full = ccnt == CW'(N);
   end

   // Each cell picks its next word from itself, a neighbor or the request word.
   always_comb begin
      ncnt = ccnt;
      for (int i = 0; i < N; i++) begin
         npx[i] = cpx[i];
         nq[i] = cq[i];
      end
      if (q_ff == '0) begin
         if (hit) begin
            ncnt = ccnt - CW'(1);
            for (int i = 0; i < N; i++) begin
               if (better[i] || !occ[i]) begin
                  // unchanged
               end else if (i + 1 < N) begin
                  npx[i] = cpx[(i + 1) % N];
                  nq[i] = cq[(i + 1) % N];
               end
            end
         end
      end else if (hit) begin
         for (int i = 0; i < N; i++) begin
            if (equal[i]) nq[i] = q_ff;
         end
      end else if (!(full && better[N-1])) begin
         if (!full) ncnt = ccnt + CW'(1);
         for (int i = 0; i < N; i++) begin
            if (better[i]) begin
               // unchanged
            end else if (i == 0 || better[(i + N - 1) % N]) begin
               npx[i] = px_ff;
               nq[i] = q_ff;
            end else begin
               npx[i] = cpx[(i + N - 1) % N];
               nq[i] = cq[(i + N - 1) % N];
            end
         end
      end
   end

   always_comb begin
      logic [PRICE_BITS-1:0] bb, ba;
      bb = (bcnt_ff != '0) ? bpx_ff[0] : '0;
      ba = (acnt_ff != '0) ? apx_ff[0] : '0;
      mid_in = (bb != '0 && ba != '0) ? ({1'b0, bb} + {1'b0, ba}) : '0;
      bcnt_in = side_ff ? ncnt : bcnt_ff;
      acnt_in = side_ff ? acnt_ff : ncnt;
   end

   // Request capture, table cells, counts and stored mid value.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= req_price;
         q_ff <= req_qty;
         side_ff <= req_side;
      end
      if (cmd.apply && px_ff != '0) begin
         for (int i = 0; i < N; i++) begin
            if (side_ff) begin
               bpx_ff[i] <= npx[i];
               bq_ff[i] <= nq[i];
            end else begin
               apx_ff[i] <= npx[i];
               aq_ff[i] <= nq[i];
            end
         end
      end
      if (reset) begin
         bcnt_ff <= '0;
         acnt_ff <= '0;
         mid_ff <= '0;
      end else begin
         if (cmd.apply && px_ff != '0) begin
            bcnt_ff <= bcnt_in;
            acnt_ff <= acnt_in;
         end
         if (cmd.publish && px_ff != '0) mid_ff <= mid_in;
      end
   end

   // Result word, held until taken.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_applied <= px_ff != '0;
         rsp_bid <= (bcnt_ff != '0) ? bpx_ff[0] : '0;
         rsp_ask <= (acnt_ff != '0) ? apx_ff[0] : '0;
         rsp_mid <= (px_ff != '0) ? mid_in : mid_ff;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/plb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module plb_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   input  wire plb_pkg::plb_status_type  status,
   output plb_pkg::plb_cmd_type          cmd
);
   import plb_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_APPLY, S_PUBLISH} state_type;
   state_type state_ff;
   logic      valid_ff;

   // A new word may enter while idle once the result slot is free or being freed.
   assign in_ready = (state_ff == S_IDLE) && (!valid_ff || out_ready);
   assign out_valid = valid_ff;

   always_comb begin
      cmd.load = in_valid && in_ready;
      cmd.apply = state_ff == S_APPLY && !status.busy;
      cmd.publish = state_ff == S_PUBLISH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && out_ready) valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd.load) state_ff <= S_APPLY;
            S_APPLY: if (cmd.apply) state_ff <= S_PUBLISH;
            S_PUBLISH: begin
               state_ff <= S_IDLE;
               valid_ff <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_APPLY) else $error("load did not start apply");
   a_pub_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> valid_ff) else $error("publish lost");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!valid_ff || out_ready)) else $error("result overrun");
endmodule
`default_nettype wire

FILE: rtl/price_level_book.sv
// price_level_book: sorted bid and ask price-level tables in a row of cells.
// Each request word passes through load, table update and result capture in order;
// the next request is not taken until the current one has been captured.
// A result waiting on the response side holds off the next request until taken.
// Synchronous reset empties both tables and clears the stored mid value (best bid plus best ask).
`timescale 1ns / 1ps
`default_nettype none
module price_level_book #(
   parameter int unsigned MAX_LEVELS = 16,
   parameter int unsigned PRICE_BITS = 32,
   parameter int unsigned QTY_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   plb_if.sink       req,
   plb_if.source     rsp
);
   import plb_pkg::*;

   plb_cmd_type    cmd;
   plb_status_type status;

   plb_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .status, .cmd
   );

   // Request word: {side, quantity, price}; response: {mid, ask, bid, applied}.
   plb_datapath #(.MAX_LEVELS(MAX_LEVELS), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS))
   u_dp (
      .clock, .reset, .cmd, .status,
      .req_price(req.data[PRICE_BITS-1:0]),
      .req_qty(req.data[PRICE_BITS+QTY_BITS-1:PRICE_BITS]),
      .req_side(req.data[PRICE_BITS+QTY_BITS]),
      .rsp_applied(rsp.data[0]),
      .rsp_bid(rsp.data[PRICE_BITS:1]),
      .rsp_ask(rsp.data[2*PRICE_BITS:PRICE_BITS+1]),
      .rsp_mid(rsp.data[3*PRICE_BITS+1:2*PRICE_BITS+1])
   );
endmodule
`default_nettype wire
